// ===== hw/rtl/ikht_pkg.sv =====
// Shared constants of the double-hashing key table.
package ikht_pkg;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_PRESENT   = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;
   localparam int SIZE_W = 11;
   localparam logic [10:0] SIZE_RESET = 11'd1021;
endpackage

// ===== hw/rtl/ikht_if.sv =====
// Valid/ready channel interfaces of the key table.
interface ikht_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] key;
   logic [31:0] value;
   modport source (output valid, mode, key, value, input ready);
   modport sink (input valid, mode, key, value, output ready);
endinterface

interface ikht_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] found_value;
   modport source (output valid, status, found_value, input ready);
   modport sink (input valid, status, found_value, output ready);
endinterface

interface ikht_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/ikht_ram.sv =====
// Generic single-port RAM with registered read data.
module ikht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write or read one entry per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/int_key_hash_table_double_hashing_top.sv =====
// Top level of the double-hashing key table.
// Each transfer hashes the key, then finds home slot and step by two bit-serial
// remainder passes, and then probes the table memory, each probe passing through a
// read, a wait and a compare state. The block is ready for the next request as soon
// as the response is raised. A finished response can wait in the output register
// while the next request is worked on; that request then waits before its response
// until the first is taken. After reset a clearing pass zeroes the occupancy memory
// before the first request is taken; configuration writes are taken at any time and
// apply from the next request transfer.
module int_key_hash_table_double_hashing_top #(
   parameter int CAPACITY = 1024
) (
   input logic clock,
   input logic reset,
   ikht_req_if.sink   req,
   ikht_rsp_if.source rsp,
   ikht_csr_if.sink   csr
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD_HOME, S_MOD_STEP, S_READ, S_WAIT,
      S_CHECK, S_RESP
   } state_type;

   state_type   state_ff;
   logic [10:0] size_cfg_ff;
   logic [CW-1:0] size_ff;
   logic        mode_ff;
   logic [31:0] key_ff, value_ff, hash_ff;
   logic [2:0]  round_ff;
   logic [4:0]  bit_ff;
   logic [CW:0] rem_ff;
   logic [AW-1:0] home_ff, step_ff, slot_ff, clr_ff;
   logic [1:0]  res_status_ff;
   logic [31:0] res_fv_ff;
   logic [1:0]  status_ff;
   logic [31:0] fv_ff;
   logic        rsp_valid_ff;

   // Memory ports.
   logic          mem_we_used, mem_we_kv;
   logic [AW-1:0] mem_addr;
   logic          used_rd;
   logic [31:0]   key_rd, val_rd;

   ikht_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used (
      .clock(clock), .wr_en(mem_we_used), .addr(mem_addr),
      .wr_data(state_ff != S_CLEAR), .rd_data(used_rd));
   ikht_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
      .clock(clock), .wr_en(mem_we_kv), .addr(mem_addr),
      .wr_data(key_ff), .rd_data(key_rd));
   ikht_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
      .clock(clock), .wr_en(mem_we_kv), .addr(mem_addr),
      .wr_data(value_ff), .rd_data(val_rd));

   // One hash round per cycle.
   logic [31:0] hash_in;
   always_comb begin
      case (round_ff)
         3'd0: hash_in = (hash_ff + 32'h7ed55d16) + (hash_ff << 12);
         3'd1: hash_in = (hash_ff ^ 32'hc761c23c) ^ (hash_ff >> 19);
         3'd2: hash_in = (hash_ff + 32'h165667b1) + (hash_ff << 5);
         3'd3: hash_in = (hash_ff + 32'hd3a2646c) ^ (hash_ff << 9);
         3'd4: hash_in = (hash_ff + 32'hfd7046c5) + (hash_ff << 3);
         default: hash_in = (hash_ff ^ 32'hb55a4f09) ^ (hash_ff >> 16);
      endcase
   end

   // Restoring remainder, one dividend bit per cycle.
   logic [CW-1:0] divisor;
   logic [CW:0]   rem_sh, rem_in;
   assign divisor = (state_ff == S_MOD_HOME) ? size_ff : size_ff - CW'(2);
   assign rem_sh  = {rem_ff[CW-1:0], hash_ff[5'd31 - bit_ff]};
   assign rem_in  = (rem_sh >= {1'b0, divisor}) ? rem_sh - {1'b0, divisor} : rem_sh;

   // Saturated effective size.
   logic [CW-1:0] size_sat;
   always_comb begin
      if (size_cfg_ff < 11'd3) size_sat = CW'(3);
      else if (32'(size_cfg_ff) > 32'(CAPACITY)) size_sat = CW'(CAPACITY);
      else size_sat = CW'(size_cfg_ff);
   end

   // Next probe slot with wrap.
   logic [AW-1:0] next_slot;
   assign next_slot = (slot_ff >= step_ff) ? slot_ff - step_ff
                    : AW'(CW'(slot_ff) + size_ff - CW'(step_ff));

   // An insert that reaches an empty slot writes it in the compare cycle.
   always_comb begin
      mem_we_kv   = (state_ff == S_CHECK) && mode_ff && !used_rd;
      mem_we_used = (state_ff == S_CLEAR) || mem_we_kv;
      mem_addr    = (state_ff == S_CLEAR) ? clr_ff : slot_ff;
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = status_ff;
   assign rsp.found_value = fv_ff;
   assign csr.ready   = 1'b1;

   // Sequencer: clear, hash, reduce, probe, respond.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         size_cfg_ff  <= ikht_pkg::SIZE_RESET;
      end else begin
         if (csr.valid && csr.ready) size_cfg_ff <= csr.data;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == CAPACITY - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  mode_ff  <= req.mode;
                  key_ff   <= req.key;
                  value_ff <= req.value;
                  hash_ff  <= req.key;
                  size_ff  <= size_sat;
                  round_ff <= 3'd0;
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               hash_ff  <= hash_in;
               round_ff <= round_ff + 3'd1;
               if (round_ff == 3'd5) begin
                  bit_ff   <= '0;
                  rem_ff   <= '0;
                  state_ff <= S_MOD_HOME;
               end
            end
            S_MOD_HOME, S_MOD_STEP: begin
               if (bit_ff == 5'd31) begin
                  bit_ff <= '0;
                  rem_ff <= '0;
                  if (state_ff == S_MOD_HOME) begin
                     home_ff  <= AW'(rem_in);
                     slot_ff  <= AW'(rem_in);
                     state_ff <= S_MOD_STEP;
                  end else begin
                     step_ff  <= AW'(rem_in + 1'b1);
                     state_ff <= S_READ;
                  end
               end else begin
                  rem_ff <= rem_in;
                  bit_ff <= bit_ff + 5'd1;
               end
            end
            S_READ: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_CHECK;
            S_CHECK: begin
               if (!used_rd) begin
                  res_status_ff <= mode_ff ? ikht_pkg::ST_OK : ikht_pkg::ST_NOT_FOUND;
                  res_fv_ff     <= '0;
                  state_ff      <= S_RESP;
               end else if (key_rd == key_ff) begin
                  res_status_ff <= mode_ff ? ikht_pkg::ST_PRESENT : ikht_pkg::ST_OK;
                  res_fv_ff     <= mode_ff ? 32'd0 : val_rd;
                  state_ff      <= S_RESP;
               end else if (next_slot == home_ff) begin
                  res_status_ff <= mode_ff ? ikht_pkg::ST_FULL : ikht_pkg::ST_NOT_FOUND;
                  res_fv_ff     <= '0;
                  state_ff      <= S_RESP;
               end else begin
                  slot_ff  <= next_slot;
                  state_ff <= S_READ;
               end
            end
            S_RESP: begin
               // The result moves to the output register once it is free.
               if (!rsp_valid_ff) begin
                  status_ff    <= res_status_ff;
                  fv_ff        <= res_fv_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A key/value write to the table only happens while probing.
   assert property (@(posedge clock) disable iff (reset)
      mem_we_kv |-> state_ff == S_CHECK) else $error("stray table write");
   // A waiting response keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(status_ff) && $stable(fv_ff))
      else $error("response changed while waiting");
   // Probe slot stays inside the table size.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> CW'(slot_ff) < size_ff) else $error("slot out of range");
endmodule

// ===== bench/tb_int_key_hash_table_double_hashing_top.sv =====
// Self-checking testbench of the double-hashing key table, with its own table predictor.
module tb_int_key_hash_table_double_hashing_top;

   localparam int CAPACITY     = 1024;
   localparam int CYCLE_LIMIT  = 10000000;
   localparam int SETTLE       = 200;
   localparam int RANDOM_ITEMS = 1425;

   // Outcomes of a probe walk through the predicted table.
   localparam int WALK_HIT   = 0;
   localparam int WALK_EMPTY = 1;
   localparam int WALK_WRAP  = 2;

   localparam logic MODE_SEARCH = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
   } table_reply_type;

   logic clock;
   logic reset;

   ikht_req_if req ();
   ikht_rsp_if rsp ();
   ikht_csr_if csr ();

   int_key_hash_table_double_hashing_top #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp),
      .csr  (csr)
   );

   // Predicted table contents and size register.
   logic [10:0] model_size;
   logic        model_used  [CAPACITY];
   logic [31:0] model_key   [CAPACITY];
   logic [31:0] model_value [CAPACITY];

   table_reply_type pending_replies[$];
   logic [31:0]  known_keys[$];
   int           mismatches;
   int           cycle_count;
   int           hold_cycles;
   bit           steady;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter that ends a hung run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Six-round integer mix of a key.
   function automatic logic [31:0] mix_key32(input logic [31:0] x);
      x = (x + 32'h7ed55d16) + (x << 12);
      x = (x ^ 32'hc761c23c) ^ (x >> 19);
      x = (x + 32'h165667b1) + (x << 5);
      x = (x + 32'hd3a2646c) ^ (x << 9);
      x = (x + 32'hfd7046c5) + (x << 3);
      x = (x ^ 32'hb55a4f09) ^ (x >> 16);
      return x;
   endfunction

   // Walks the probe sequence of a key; returns the outcome and the slot where it stopped.
   function automatic int walk_table(input logic [31:0] key, output int slot);
      int unsigned sz;
      int unsigned h;
      int unsigned home;
      int unsigned stride;
      int unsigned j;
      sz = 32'(model_size);
      if (sz < 3) sz = 3;
      if (sz > CAPACITY) sz = CAPACITY;
      h      = mix_key32(key);
      home   = h % sz;
      stride = h % (sz - 2) + 1;
      j      = home;
      for (int n = 0; n <= sz; n++) begin
         if (n > 0) begin
            j = (j >= stride) ? j - stride : j + sz - stride;
            if (j == home) break;
         end
         slot = j;
         if (!model_used[j]) return WALK_EMPTY;
         if (model_key[j] == key) return WALK_HIT;
      end
      slot = home;
      return WALK_WRAP;
   endfunction

   // Applies one accepted request to the predicted table and queues its reply.
   task automatic predict_reply(input logic mode, input logic [31:0] key,
                                input logic [31:0] value);
      table_reply_type r;
      int           slot;
      int           outcome;
      outcome       = walk_table(key, slot);
      r.found_value = '0;
      if (mode == MODE_SEARCH) begin
         if (outcome == WALK_HIT) begin
            r.status      = ikht_pkg::ST_OK;
            r.found_value = model_value[slot];
         end else begin
            r.status = ikht_pkg::ST_NOT_FOUND;
         end
      end else if (outcome == WALK_HIT) begin
         r.status = ikht_pkg::ST_PRESENT;
      end else if (outcome == WALK_EMPTY) begin
         model_used[slot]  = 1'b1;
         model_key[slot]   = key;
         model_value[slot] = value;
         r.status          = ikht_pkg::ST_OK;
      end else begin
         r.status = ikht_pkg::ST_FULL;
      end
      pending_replies.push_back(r);
   endtask

   // Sends one request, idling at random first, and predicts it on transfer.
   task automatic send_request(input logic mode, input logic [31:0] key,
                               input logic [31:0] value);
      while (!steady && $urandom_range(99) < 32) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.mode  = mode;
      req.key   = key;
      req.value = value;
      do @(posedge clock); while (!req.ready);
      predict_reply(mode, key, value);
      known_keys.push_back(key);
      if (known_keys.size() > 64) void'(known_keys.pop_front());
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   // Waits until every reply is in, then lets the block settle.
   task automatic wait_drained();
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes the size register while the block is idle.
   task automatic write_size(input logic [10:0] sz);
      wait_drained();
      csr.valid = 1'b1;
      csr.data  = sz;
      do @(posedge clock); while (!csr.ready);
      model_size = sz;
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // Receiver: idles at random, or holds off for a counted stretch.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready   <= 1'b0;
      end else begin
         rsp.ready <= steady || ($urandom_range(99) >= 32);
      end
   end

   // Reply checker against the oldest prediction.
   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected reply, expected none, actual status %0d value %h",
                     $time, rsp.status, rsp.found_value);
         end else begin
            want = pending_replies.pop_front();
            if (rsp.status !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp.status);
            end
            if (rsp.found_value !== want.found_value) begin
               mismatches++;
               $display("%0t: found_value expected %h actual %h",
                        $time, want.found_value, rsp.found_value);
            end
         end
      end
   end

   // Extreme keys and values at the reset size, hits, misses and duplicates.
   task automatic test_extremes();
      send_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(MODE_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(MODE_SEARCH, 32'h1234_5678, 32'h0);
      send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h5555_5555);
      send_request(MODE_SEARCH, 32'hFFFF_FFFF, 32'h0);
   endtask

   // Smallest table: fill it, then a full insert and a search that wraps.
   task automatic test_full_table();
      write_size(11'd3);
      for (int i = 0; i < 4; i++) send_request(MODE_INSERT, 32'hA000_0000 + i, $urandom);
      send_request(MODE_SEARCH, 32'hBEEF_0001, 32'h0);
      send_request(MODE_SEARCH, 32'hA000_0001, 32'h0);
   endtask

   // Sizes below and above the legal range, and sizes that are not prime.
   task automatic test_odd_sizes();
      write_size(11'd0);
      send_request(MODE_SEARCH, 32'hA000_0002, 32'h0);
      send_request(MODE_INSERT, 32'hC000_0000, 32'h1111_1111);
      write_size(11'd2);
      send_request(MODE_SEARCH, 32'hC000_0000, 32'h0);
      write_size(11'd2047);
      send_request(MODE_INSERT, 32'hC000_0001, 32'h2222_2222);
      send_request(MODE_SEARCH, 32'hC000_0001, 32'h0);
      write_size(11'd4);
      for (int i = 0; i < 4; i++) send_request(MODE_INSERT, 32'hD000_0000 + i, $urandom);
      write_size(11'd1024);
      send_request(MODE_SEARCH, 32'hC000_0001, 32'h0);
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      write_size(11'd1021);
      hold_cycles = 1500;
      for (int i = 0; i < 12; i++) send_request(1'(i % 2), $urandom, $urandom);
   endtask

   // Random phases over a set of sizes, mostly primes, keys often reused.
   task automatic test_random_traffic();
      int unsigned primes[11] = '{3, 5, 7, 11, 13, 31, 61, 127, 251, 509, 1021};
      int          sent;
      int          phase;
      int          burst;
      logic [31:0] key;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(9) == 0) write_size(11'($urandom_range(40)));
         else write_size(11'(primes[$urandom_range(10)]));
         steady = (phase == 2);
         burst  = $urandom_range(20, 120);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            if (known_keys.size() != 0 && $urandom_range(1))
               key = known_keys[$urandom_range(known_keys.size() - 1)];
            else
               key = $urandom;
            send_request(1'($urandom_range(1)), key, $urandom);
            sent++;
         end
         steady = 1'b0;
         phase++;
      end
   endtask

   // Test sequence.
   initial begin
      mismatches  = 0;
      hold_cycles = 0;
      steady      = 1'b0;
      model_size  = ikht_pkg::SIZE_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
         model_used[i]  = 1'b0;
         model_key[i]   = '0;
         model_value[i] = '0;
      end
      reset     = 1'b1;
      req.valid = 1'b0;
      req.mode  = 1'b0;
      req.key   = '0;
      req.value = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_full_table();
      test_odd_sizes();
      test_backpressure();
      test_random_traffic();
      wait_drained();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
